### rtl/core/fas_pkg.sv
// fas_pkg: command and status codes for the fifo and stack block
// no dependencies; imported by the store logic, the top level and the checker
package fas_pkg;

   // widths of the command code, the status code and the piece type
   localparam int KIND_BITS   = 3;
   localparam int STATUS_BITS = 3;
   localparam int TYPE_BITS   = 2;

   // entries moved by the multi-entry swap
   localparam int SWAP_SPAN = 3;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ENQ   = 3'd0,
      KIND_DEQ   = 3'd1,
      KIND_PUSH  = 3'd2,
      KIND_POP   = 3'd3,
      KIND_SWAP1 = 3'd4,
      KIND_SWAP3 = 3'd5
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK          = 3'd0,
      ST_FIFO_FULL   = 3'd1,
      ST_FIFO_EMPTY  = 3'd2,
      ST_STACK_FULL  = 3'd3,
      ST_STACK_EMPTY = 3'd4,
      ST_TOO_FEW     = 3'd5
   } status_type;

   // control handed from the request register to the store logic
   typedef struct packed {
      logic                 exec;
      logic [KIND_BITS-1:0] kind;
   } ctrl_type;

endpackage

### rtl/core/fas_if.sv
// fas_if: valid/ready channels for requests and responses
// depends on fas_pkg for the code widths
interface fas_req_if
   import fas_pkg::*;
#(
   parameter int TAG_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic [KIND_BITS-1:0] kind;
   logic [TYPE_BITS-1:0] piece_type;
   logic [TAG_BITS-1:0]  piece_tag;

   modport source (output valid, kind, piece_type, piece_tag, input ready);
   modport sink   (input valid, kind, piece_type, piece_tag, output ready);
endinterface

interface fas_rsp_if
   import fas_pkg::*;
#(
   parameter int TAG_BITS = 16,
   parameter int FLW      = 3,
   parameter int SLW      = 2
);
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [TYPE_BITS-1:0]   out_type;
   logic [TAG_BITS-1:0]    out_tag;
   logic [FLW-1:0]         fifo_level;
   logic [SLW-1:0]         stack_level;

   modport source (output valid, status, out_type, out_tag, fifo_level, stack_level,
                   input ready);
   modport sink   (input valid, status, out_type, out_tag, fifo_level, stack_level,
                   output ready);
endinterface

### rtl/core/fas_stores.sv
// fas_stores: shift-register fifo and stack with the command logic
// depends on fas_pkg; the fifo head and the stack top both sit at entry 0
module fas_stores
   import fas_pkg::*;
#(
   parameter int FIFO_DEPTH  = 5,
   parameter int STACK_DEPTH = 3,
   parameter int TAG_BITS    = 16,
   parameter int FLW         = 3,
   parameter int SLW         = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_type             ctrl,
   input  logic [TYPE_BITS-1:0] in_type,
   input  logic [TAG_BITS-1:0]  in_tag,
   output status_type           status,
   output logic [TYPE_BITS-1:0] out_type,
   output logic [TAG_BITS-1:0]  out_tag,
   output logic [FLW-1:0]       fifo_level,
   output logic [SLW-1:0]       stack_level
);
   localparam int EW = TYPE_BITS + TAG_BITS;

   logic [EW-1:0]  fifo_ff  [FIFO_DEPTH];
   logic [EW-1:0]  fifo_in  [FIFO_DEPTH];
   logic [EW-1:0]  stack_ff [STACK_DEPTH];
   logic [EW-1:0]  stack_in [STACK_DEPTH];
   logic [FLW-1:0] fifo_cnt_ff;
   logic [FLW-1:0] fifo_cnt_in;
   logic [SLW-1:0] stack_cnt_ff;
   logic [SLW-1:0] stack_cnt_in;
   logic [EW-1:0]  entry;
   logic [EW-1:0]  removed;

   assign entry = {in_type, in_tag};

   always_comb begin
      fifo_in      = fifo_ff;
      stack_in     = stack_ff;
      fifo_cnt_in  = fifo_cnt_ff;
      stack_cnt_in = stack_cnt_ff;
      removed      = '0;
      status       = ST_OK;
      case (ctrl.kind)
         KIND_ENQ: begin
            if (fifo_cnt_ff == FLW'(FIFO_DEPTH)) begin
               status = ST_FIFO_FULL;
            end else begin
               for (int i = 0; i < FIFO_DEPTH; i++) begin
                  if (FLW'(i) == fifo_cnt_ff) begin
                     fifo_in[i] = entry;
                  end
               end
               fifo_cnt_in = fifo_cnt_ff + FLW'(1);
            end
         end
         KIND_DEQ: begin
            if (fifo_cnt_ff == '0) begin
               status = ST_FIFO_EMPTY;
            end else begin
               removed = fifo_ff[0];
               for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
                  fifo_in[i] = fifo_ff[i+1];
               end
               fifo_cnt_in = fifo_cnt_ff - FLW'(1);
            end
         end
         KIND_PUSH: begin
            if (stack_cnt_ff == SLW'(STACK_DEPTH)) begin
               status = ST_STACK_FULL;
            end else begin
               stack_in[0] = entry;
               for (int i = 1; i < STACK_DEPTH; i++) begin
                  stack_in[i] = stack_ff[i-1];
               end
               stack_cnt_in = stack_cnt_ff + SLW'(1);
            end
         end
         KIND_POP: begin
            if (stack_cnt_ff == '0) begin
               status = ST_STACK_EMPTY;
            end else begin
               removed = stack_ff[0];
               for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                  stack_in[i] = stack_ff[i+1];
               end
               stack_cnt_in = stack_cnt_ff - SLW'(1);
            end
         end
         KIND_SWAP1: begin
            // stack is tested before the fifo
            if (stack_cnt_ff == '0) begin
               status = ST_STACK_EMPTY;
            end else if (fifo_cnt_ff == '0) begin
               status = ST_FIFO_EMPTY;
            end else begin
               fifo_in[0]  = stack_ff[0];
               stack_in[0] = fifo_ff[0];
            end
         end
         KIND_SWAP3: begin
            if (fifo_cnt_ff < FLW'(SWAP_SPAN) || stack_cnt_ff < SLW'(SWAP_SPAN)) begin
               status = ST_TOO_FEW;
            end else begin
               for (int i = 0; i < SWAP_SPAN; i++) begin
                  fifo_in[i]  = stack_ff[i];
                  stack_in[i] = fifo_ff[i];
               end
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign out_type    = removed[EW-1:TAG_BITS];
   assign out_tag     = removed[TAG_BITS-1:0];
   assign fifo_level  = fifo_cnt_in;
   assign stack_level = stack_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_cnt_ff  <= '0;
         stack_cnt_ff <= '0;
      end else if (ctrl.exec) begin
         fifo_cnt_ff  <= fifo_cnt_in;
         stack_cnt_ff <= stack_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         fifo_ff  <= fifo_in;
         stack_ff <= stack_in;
      end
   end

endmodule

### rtl/core/fifo_and_stack_with_swap_top.sv
// fifo_and_stack_with_swap_top: five-entry fifo and three-entry stack with swaps
// path: an accepted request waits in the request register, then its result is captured in the response register
// throughput: one request per cycle while the receiver takes responses; the store update
//    is a single pass of logic between the request register and the response register
// reset: synchronous, clears both occupancies and both valid flags
// depends on fas_pkg, fas_if and fas_stores
module fifo_and_stack_with_swap_top
   import fas_pkg::*;
#(
   parameter int FIFO_DEPTH  = 5,
   parameter int STACK_DEPTH = 3,
   parameter int TAG_BITS    = 16
) (
   input  logic    clock,
   input  logic    reset,
   fas_req_if.sink   req,
   fas_rsp_if.source rsp
);
   // occupancy widths follow the depths
   localparam int FLW = $clog2(FIFO_DEPTH + 1);
   localparam int SLW = $clog2(STACK_DEPTH + 1);

   // request register
   logic                 req_valid_ff;
   logic                 req_valid_in;
   logic [KIND_BITS-1:0] req_kind_ff;
   logic [TYPE_BITS-1:0] req_type_ff;
   logic [TAG_BITS-1:0]  req_tag_ff;

   // response register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   status_type           rsp_status_ff;
   logic [TYPE_BITS-1:0] rsp_type_ff;
   logic [TAG_BITS-1:0]  rsp_tag_ff;
   logic [FLW-1:0]       rsp_flevel_ff;
   logic [SLW-1:0]       rsp_slevel_ff;

   // results of the store logic for the request being executed
   status_type           exe_status;
   logic [TYPE_BITS-1:0] exe_type;
   logic [TAG_BITS-1:0]  exe_tag;
   logic [FLW-1:0]       exe_flevel;
   logic [SLW-1:0]       exe_slevel;

   logic     advance;
   logic     req_take;
   ctrl_type ctrl;

   // a held request moves on when the response register is empty or draining
   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !req_valid_ff || advance;
   assign req_take = req.valid && req.ready;

   assign ctrl.exec = advance;
   assign ctrl.kind = req_kind_ff;

   fas_stores #(
      .FIFO_DEPTH  (FIFO_DEPTH),
      .STACK_DEPTH (STACK_DEPTH),
      .TAG_BITS    (TAG_BITS),
      .FLW         (FLW),
      .SLW         (SLW)
   ) u_stores (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .in_type     (req_type_ff),
      .in_tag      (req_tag_ff),
      .status      (exe_status),
      .out_type    (exe_type),
      .out_tag     (exe_tag),
      .fifo_level  (exe_flevel),
      .stack_level (exe_slevel)
   );

   // valid flags: request slot refills in the cycle it empties
   always_comb begin
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_kind_ff <= req.kind;
         req_type_ff <= req.piece_type;
         req_tag_ff  <= req.piece_tag;
      end
      if (advance) begin
         rsp_status_ff <= exe_status;
         rsp_type_ff   <= exe_type;
         rsp_tag_ff    <= exe_tag;
         rsp_flevel_ff <= exe_flevel;
         rsp_slevel_ff <= exe_slevel;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.out_type    = rsp_type_ff;
   assign rsp.out_tag     = rsp_tag_ff;
   assign rsp.fifo_level  = rsp_flevel_ff;
   assign rsp.stack_level = rsp_slevel_ff;

endmodule

### rtl/core/fas_checker.sv
// fas_port_checks: port-level checks on the fifo and stack block
// depends on fas_pkg; bound to fifo_and_stack_with_swap_top below
module fas_port_checks
   import fas_pkg::*;
#(
   parameter int FIFO_DEPTH  = 5,
   parameter int STACK_DEPTH = 3,
   parameter int TAG_BITS    = 16,
   parameter int FLW         = 3,
   parameter int SLW         = 2
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STATUS_BITS-1:0] rsp_status,
   input logic [TYPE_BITS-1:0]   rsp_out_type,
   input logic [TAG_BITS-1:0]    rsp_out_tag,
   input logic [FLW-1:0]         rsp_fifo_level,
   input logic [SLW-1:0]         rsp_stack_level
);

   // a stalled response keeps its status, tag and fifo level
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_tag) && $stable(rsp_fifo_level))
      else $error("stalled response changed");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // occupancies stay within the depths
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fifo_level <= FLW'(FIFO_DEPTH)
         && rsp_stack_level <= SLW'(STACK_DEPTH))
      else $error("occupancy out of range");

   // a fifo-full report means the fifo really is full
   a_full_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FIFO_FULL |-> rsp_fifo_level == FLW'(FIFO_DEPTH))
      else $error("fifo full reported below depth");

   // an empty-stack report leaves nothing removed and an empty stack
   a_empty_stack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_STACK_EMPTY |->
         rsp_stack_level == '0 && rsp_out_tag == '0 && rsp_out_type == '0)
      else $error("stack empty report inconsistent");

endmodule

bind fifo_and_stack_with_swap_top fas_port_checks #(
   .FIFO_DEPTH  (FIFO_DEPTH),
   .STACK_DEPTH (STACK_DEPTH),
   .TAG_BITS    (TAG_BITS),
   .FLW         (FLW),
   .SLW         (SLW)
) u_fas_port_checks (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_out_type    (rsp.out_type),
   .rsp_out_tag     (rsp.out_tag),
   .rsp_fifo_level  (rsp.fifo_level),
   .rsp_stack_level (rsp.stack_level)
);

### tb/fas_checker.sv
// fas_checker: watches both channels of the fifo and stack block, keeps its own copy of
// both stores and compares every response with the predicted one
// depends on fas_pkg and the channel interfaces in fas_if
module fas_checker
   import fas_pkg::*;
#(
   parameter int FIFO_DEPTH  = 5,
   parameter int STACK_DEPTH = 3,
   parameter int TAG_BITS    = 16
) (
   input  logic clock,
   input  logic reset,
   fas_req_if   req,
   fas_rsp_if   rsp,
   output int   fail_count,
   output int   pending,
   output int   checked,
   output int   swaps_done,
   output int   refusals
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PW  = $clog2(FIFO_DEPTH);
   localparam int FLW = $clog2(FIFO_DEPTH + 1);
   localparam int SLW = $clog2(STACK_DEPTH + 1);

   typedef struct packed {
      logic [TYPE_BITS-1:0] ptype;
      logic [TAG_BITS-1:0]  tag;
   } piece_t;

   typedef struct packed {
      status_type           status;
      logic [TYPE_BITS-1:0] out_type;
      logic [TAG_BITS-1:0]  out_tag;
      logic [FLW-1:0]       fifo_level;
      logic [SLW-1:0]       stack_level;
   } outcome_t;

   piece_t         fifo_mem [FIFO_DEPTH];
   piece_t         stack_mem [STACK_DEPTH];
   logic [PW-1:0]  head_idx;
   logic [PW-1:0]  tail_idx;
   logic [FLW-1:0] fifo_fill;
   logic [SLW-1:0] stack_fill;
   outcome_t       awaited_q [$];

   function automatic logic [PW-1:0] next_slot(logic [PW-1:0] p);
      return (int'(p) == FIFO_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   // one command against the shadow stores; refused commands leave them untouched
   task automatic apply_command(input logic [KIND_BITS-1:0] kind, input piece_t piece,
                                output outcome_t res);
      piece_t held;
      int     fi;
      int     si;
      res        = '0;
      res.status = ST_OK;
      case (kind)
         KIND_ENQ: begin
            if (int'(fifo_fill) >= FIFO_DEPTH) begin
               res.status = ST_FIFO_FULL;
            end else begin
               fifo_mem[tail_idx] = piece;
               tail_idx           = next_slot(tail_idx);
               fifo_fill++;
            end
         end
         KIND_DEQ: begin
            if (fifo_fill == 0) begin
               res.status = ST_FIFO_EMPTY;
            end else begin
               res.out_type = fifo_mem[head_idx].ptype;
               res.out_tag  = fifo_mem[head_idx].tag;
               head_idx     = next_slot(head_idx);
               fifo_fill--;
            end
         end
         KIND_PUSH: begin
            if (int'(stack_fill) >= STACK_DEPTH) begin
               res.status = ST_STACK_FULL;
            end else begin
               stack_mem[stack_fill] = piece;
               stack_fill++;
            end
         end
         KIND_POP: begin
            if (stack_fill == 0) begin
               res.status = ST_STACK_EMPTY;
            end else begin
               stack_fill--;
               res.out_type = stack_mem[stack_fill].ptype;
               res.out_tag  = stack_mem[stack_fill].tag;
            end
         end
         KIND_SWAP1: begin
            // the stack is tested first when both are empty
            if (stack_fill == 0) begin
               res.status = ST_STACK_EMPTY;
            end else if (fifo_fill == 0) begin
               res.status = ST_FIFO_EMPTY;
            end else begin
               si                 = int'(stack_fill) - 1;
               held               = fifo_mem[head_idx];
               fifo_mem[head_idx] = stack_mem[si];
               stack_mem[si]      = held;
            end
         end
         KIND_SWAP3: begin
            if (int'(fifo_fill) < SWAP_SPAN || int'(stack_fill) < SWAP_SPAN) begin
               res.status = ST_TOO_FEW;
            end else begin
               for (int i = 0; i < SWAP_SPAN; i++) begin
                  fi            = (int'(head_idx) + i) % FIFO_DEPTH;
                  si            = int'(stack_fill) - 1 - i;
                  held          = fifo_mem[fi];
                  fifo_mem[fi]  = stack_mem[si];
                  stack_mem[si] = held;
               end
            end
         end
         default: ;
      endcase
      res.fifo_level  = fifo_fill;
      res.stack_level = stack_fill;
   endtask

   function automatic int field_mismatch(string field, logic [31:0] want, logic [31:0] got);
      if (want === got) return 0;
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      outcome_t due;
      outcome_t fresh;
      piece_t   piece;
      int       errs;
      errs = 0;
      if (reset) begin
         head_idx   = '0;
         tail_idx   = '0;
         fifo_fill  = '0;
         stack_fill = '0;
         awaited_q.delete();
         fail_count <= 0;
         pending    <= 0;
         checked    <= 0;
         swaps_done <= 0;
         refusals   <= 0;
      end else begin
         // responses first, so one cannot pair with a request taken at the same edge
         if (rsp.valid && rsp.ready) begin
            if (awaited_q.size() == 0) begin
               $error("response with status %0d arrived with no request outstanding",
                      rsp.status);
               errs++;
            end else begin
               due  = awaited_q.pop_front();
               errs += field_mismatch("status", due.status, rsp.status);
               errs += field_mismatch("out_type", due.out_type, rsp.out_type);
               errs += field_mismatch("out_tag", due.out_tag, rsp.out_tag);
               errs += field_mismatch("fifo_level", due.fifo_level, rsp.fifo_level);
               errs += field_mismatch("stack_level", due.stack_level, rsp.stack_level);
            end
            checked <= checked + 1;
         end
         if (req.valid && req.ready) begin
            piece.ptype = req.piece_type;
            piece.tag   = req.piece_tag;
            apply_command(req.kind, piece, fresh);
            awaited_q.push_back(fresh);
            if (fresh.status != ST_OK) refusals <= refusals + 1;
            if (fresh.status == ST_OK && req.kind == KIND_SWAP3)
               swaps_done <= swaps_done + 1;
         end
         fail_count <= fail_count + errs;
         pending    <= awaited_q.size();
      end
   end

endmodule

### tb/tb_fifo_and_stack_with_swap_top.sv
// tb_fifo_and_stack_with_swap_top: stimulus and verdict for the fifo and stack block
// depends on fas_pkg, fas_if, the block itself and fas_checker
module tb_fifo_and_stack_with_swap_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fas_pkg::*;

   localparam int FIFO_DEPTH   = 5;
   localparam int STACK_DEPTH  = 3;
   localparam int TAG_BITS     = 16;
   localparam int RANDOM_ITEMS = 1900;
   // far above the slowest legal run of a couple of thousand requests
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;

   // kind codes the block has no operation for
   localparam logic [KIND_BITS-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [KIND_BITS-1:0] KIND_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int req_idle_pct;
   int rsp_idle_pct;
   int sent;
   int cycle_count;
   int fail_count;
   int pending;
   int checked;
   int swaps_done;
   int refusals;

   fas_req_if #(.TAG_BITS(TAG_BITS)) req_bus ();
   fas_rsp_if #(.TAG_BITS(TAG_BITS), .FLW(3), .SLW(2)) rsp_bus ();

   fifo_and_stack_with_swap_top #(
      .FIFO_DEPTH  (FIFO_DEPTH),
      .STACK_DEPTH (STACK_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   fas_checker #(
      .FIFO_DEPTH  (FIFO_DEPTH),
      .STACK_DEPTH (STACK_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .swaps_done (swaps_done),
      .refusals   (refusals)
   );

   // 2 ns period
   always #1ns clock = ~clock;

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99, 0) >= rsp_idle_pct);
   end

   // watchdog: a hung handshake or a lost response ends up here
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // tags lean on the extremes now and then so every bit toggles both ways
   function automatic logic [TAG_BITS-1:0] pick_tag();
      case ($urandom_range(7, 0))
         0:       return '0;
         1:       return '1;
         default: return TAG_BITS'($urandom_range(65535, 0));
      endcase
   endfunction

   // one request, with a random gap in front of it; returns in the step of acceptance
   task automatic send_request(input logic [KIND_BITS-1:0] kind,
                               input logic [TYPE_BITS-1:0] ptype,
                               input logic [TAG_BITS-1:0]  tag);
      while ($urandom_range(99, 0) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.piece_type <= ptype;
      req_bus.piece_tag  <= tag;
      do @(posedge clock); while (!req_bus.ready);
      sent++;
   endtask

   // hold the sender off until every outstanding response is back
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // single command drawn with weights that keep both stores moving up and down
   task automatic random_command();
      logic [KIND_BITS-1:0] kind;
      int                   pick;
      pick = $urandom_range(99, 0);
      if (pick < 22)      kind = KIND_ENQ;
      else if (pick < 40) kind = KIND_DEQ;
      else if (pick < 58) kind = KIND_PUSH;
      else if (pick < 72) kind = KIND_POP;
      else if (pick < 84) kind = KIND_SWAP1;
      else if (pick < 97) kind = KIND_SWAP3;
      else if (pick < 98) kind = KIND_SPARE_LO;
      else                kind = KIND_SPARE_HI;
      send_request(kind, TYPE_BITS'($urandom_range(3, 0)), pick_tag());
   endtask

   // well-formed sequence: fill both stores, swap a few times, then drain some or all of each
   task automatic fill_and_swap();
      repeat (FIFO_DEPTH)
         send_request(KIND_ENQ, TYPE_BITS'($urandom_range(3, 0)), pick_tag());
      repeat (STACK_DEPTH)
         send_request(KIND_PUSH, TYPE_BITS'($urandom_range(3, 0)), pick_tag());
      repeat ($urandom_range(3, 1)) begin
         if ($urandom_range(2, 0) == 0) send_request(KIND_SWAP1, '0, '0);
         else send_request(KIND_SWAP3, '0, '0);
      end
      repeat ($urandom_range(FIFO_DEPTH, 0)) send_request(KIND_DEQ, '0, '0);
      repeat ($urandom_range(STACK_DEPTH, 0)) send_request(KIND_POP, '0, '0);
   endtask

   // random part of one idling phase, mostly well-formed sequences, rest is noise
   task automatic run_phase(input int items);
      int target;
      target = sent + items;
      while (sent < target) begin
         if ($urandom_range(3, 0) == 0) fill_and_swap();
         else random_command();
      end
   endtask

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.kind       = KIND_ENQ;
      req_bus.piece_type = '0;
      req_bus.piece_tag  = '0;
      rsp_bus.ready      = 1'b0;
      sent               = 0;
      // first phase: sender idles less than the receiver
      req_idle_pct       = 37;
      rsp_idle_pct       = 53;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // everything empty: each removal and swap is refused
      send_request(KIND_DEQ, '0, '0);
      send_request(KIND_POP, '0, '0);
      send_request(KIND_SWAP1, '0, '0);   // stack checked before fifo
      send_request(KIND_SWAP3, '0, '0);
      send_request(KIND_SPARE_LO, 2'd3, '1);
      send_request(KIND_SPARE_HI, 2'd3, '1);

      // stack to full and one beyond
      send_request(KIND_PUSH, 2'd0, '0);
      send_request(KIND_PUSH, 2'd3, '1);
      send_request(KIND_PUSH, 2'd1, 16'h5a5a);
      send_request(KIND_PUSH, 2'd2, 16'ha5a5);

      // stack full but fifo empty
      send_request(KIND_SWAP1, '0, '0);

      // fifo to full and one beyond
      send_request(KIND_ENQ, 2'd3, '0);
      send_request(KIND_ENQ, 2'd0, '1);
      send_request(KIND_ENQ, 2'd2, 16'h8001);
      send_request(KIND_ENQ, 2'd1, 16'h7ffe);
      send_request(KIND_ENQ, 2'd3, '1);
      send_request(KIND_ENQ, 2'd1, 16'h1234);

      // both swaps succeed, then removals bring back the swapped entries
      send_request(KIND_SWAP1, '0, '0);
      send_request(KIND_SWAP3, '0, '0);
      send_request(KIND_DEQ, '0, '0);
      send_request(KIND_POP, '0, '0);
      // fifo has four but stack only two now
      send_request(KIND_SWAP3, '0, '0);

      run_phase(RANDOM_ITEMS / 3);
      // sender waits for the block to empty its response path
      drain_responses();

      // second phase: roles reversed
      req_idle_pct = 53;
      rsp_idle_pct = 37;
      run_phase(RANDOM_ITEMS / 3);
      drain_responses();

      // last phase: no idling on either side
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests over three idling phases, %0d responses checked",
               sent, checked);
      $display("%0d three-entry swaps done, %0d requests refused on full, empty or short",
               swaps_done, refusals);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
